/* rtl/odr_pkg.sv */
package odr_pkg;

   localparam int CORDIC_STEPS = 16;
   localparam int ATAN_ENTRIES = 24;
   localparam int CORDIC_ITERS = (CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STEPS;
   localparam int ITER_W       = $clog2(CORDIC_ITERS + 1);
   localparam int ATAN_IDX_W   = $clog2(ATAN_ENTRIES);

   typedef logic signed [15:0] angle_type;
   typedef logic signed [31:0] q30_type;
   typedef logic signed [31:0] dist_type;
   typedef logic signed [47:0] pos_type;
   typedef logic        [15:0] thresh_type;

   localparam q30_type   CORDIC_GAIN   = 32'sd652032874;
   localparam thresh_type THRESH_RESET = 16'd655;

   // arctangent of 2^-i in units of a 32-bit binary angle
   function automatic q30_type atan_val(input logic [ATAN_IDX_W-1:0] idx);
      q30_type v;
      case (idx)
         5'd0:    v = 32'sd536870912;
         5'd1:    v = 32'sd316933406;
         5'd2:    v = 32'sd167458907;
         5'd3:    v = 32'sd85004756;
         5'd4:    v = 32'sd42667331;
         5'd5:    v = 32'sd21354465;
         5'd6:    v = 32'sd10679838;
         5'd7:    v = 32'sd5340245;
         5'd8:    v = 32'sd2670163;
         5'd9:    v = 32'sd1335087;
         5'd10:   v = 32'sd667544;
         5'd11:   v = 32'sd333772;
         5'd12:   v = 32'sd166886;
         5'd13:   v = 32'sd83443;
         5'd14:   v = 32'sd41722;
         5'd15:   v = 32'sd20861;
         5'd16:   v = 32'sd10430;
         5'd17:   v = 32'sd5215;
         5'd18:   v = 32'sd2608;
         5'd19:   v = 32'sd1304;
         5'd20:   v = 32'sd652;
         5'd21:   v = 32'sd326;
         5'd22:   v = 32'sd163;
         5'd23:   v = 32'sd81;
         default: v = '0;
      endcase
      return v;
   endfunction

   typedef enum logic [8:0] {
      S_IDLE  = 9'b000000001,
      S_HEAD  = 9'b000000010,
      S_PITCH = 9'b000000100,
      S_R11   = 9'b000001000,
      S_R21   = 9'b000010000,
      S_PX    = 9'b000100000,
      S_PY    = 9'b001000000,
      S_PZ    = 9'b010000000,
      S_ZACC  = 9'b100000000
   } state_type;

endpackage

/* rtl/odr_if.sv */
interface odr_req_if;
   logic                    valid;
   logic                    ready;
   logic                    imu_valid;
   logic signed [15:0]      yaw_raw;
   logic signed [15:0]      pitch_angle;
   logic signed [31:0]      travelled;
   logic signed [31:0]      speed;

   modport source (output valid, imu_valid, yaw_raw, pitch_angle, travelled, speed,
                   input ready);
   modport sink   (input valid, imu_valid, yaw_raw, pitch_angle, travelled, speed,
                   output ready);
endinterface

interface odr_rsp_if;
   logic                    valid;
   logic                    ready;
   logic signed [47:0]      pos_x;
   logic signed [47:0]      pos_y;
   logic signed [47:0]      pos_z;
   logic signed [15:0]      heading;

   modport source (output valid, pos_x, pos_y, pos_z, heading, input ready);
   modport sink   (input valid, pos_x, pos_y, pos_z, heading, output ready);
endinterface

/* rtl/odometry_imu_dead_reckoning.sv */
// 3D dead reckoning from odometry distance and IMU yaw/pitch. Each valid beat
// after the first gives one position beat (x, y, z in Q32.16, wrapping) plus the
// drift-corrected heading. Beats with imu_valid low are consumed and change
// nothing; the first valid beat latches the yaw origin and distance. A producing
// beat is accepted, then makes the heading and pitch passes through the single
// iterative CORDIC (one rotation a cycle, 16 rotations), then uses the shared
// 32x32 multiplier and the three accumulators. req is ready only while the
// sequencer is idle; a finished result sits in its own output register, so the
// next beat may enter while it waits; the last step holds while it is unread.
module odometry_imu_dead_reckoning (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  odr_pkg::thresh_type csr_wdata,
   odr_req_if.sink             req_bus,
   odr_rsp_if.source           rsp_bus
);
   import odr_pkg::*;

   state_type   state_ff, state_in;
   thresh_type  thr_ff;
   logic        started_ff, started_in;
   angle_type   origin_ff, origin_in, yaw_prev_ff, yaw_prev_in, drift_ff, drift_in;
   angle_type   head_ff, head_in, pitch_ff, pitch_in;
   dist_type    dist_prev_ff, dist_prev_in, dist_ff, dist_in;
   q30_type     ch_ff, ch_in, sh_ff, sh_in, cp_ff, cp_in, sp_ff, sp_in;
   q30_type     r11_ff, r11_in, r21_ff, r21_in;
   pos_type     x_ff, x_in, y_ff, y_in, z_ff, z_in;
   pos_type     rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in, rsp_z_ff, rsp_z_in;
   angle_type   rsp_head_ff, rsp_head_in;
   logic        rsp_valid_ff, rsp_valid_in;

   logic        req_beat;
   logic [31:0] spd_mag;
   angle_type   drift_new, head_new;
   logic        cord_start, cord_busy;
   angle_type   cord_angle;
   q30_type     cord_cos, cord_sin;
   logic        mul_en;
   q30_type     mul_a, mul_b;
   logic signed [63:0] prod;
   pos_type     inc;

   assign req_beat = req_bus.valid && req_bus.ready;
   // -2^31 maps to 2^31 in unsigned form
   assign spd_mag  = req_bus.speed[31] ? 32'(-req_bus.speed) : 32'(req_bus.speed);
   assign drift_new = (spd_mag < {16'd0, thr_ff})
                      ? drift_ff + req_bus.yaw_raw - yaw_prev_ff : drift_ff;
   assign head_new = req_bus.yaw_raw - origin_ff - drift_new;
   assign inc      = {{14{prod[63]}}, prod[63:30]};

   odr_cordic u_cordic (
      .clock (clock),
      .reset (reset),
      .start (cord_start),
      .angle (cord_angle),
      .busy  (cord_busy),
      .cos_q (cord_cos),
      .sin_q (cord_sin)
   );

   odr_mul u_mul (
      .clock  (clock),
      .enable (mul_en),
      .op_a   (mul_a),
      .op_b   (mul_b),
      .prod   (prod)
   );

   always_comb begin
      state_in     = state_ff;
      started_in   = started_ff;
      origin_in    = origin_ff;
      yaw_prev_in  = yaw_prev_ff;
      drift_in     = drift_ff;
      head_in      = head_ff;
      pitch_in     = pitch_ff;
      dist_prev_in = dist_prev_ff;
      dist_in      = dist_ff;
      ch_in        = ch_ff;
      sh_in        = sh_ff;
      cp_in        = cp_ff;
      sp_in        = sp_ff;
      r11_in       = r11_ff;
      r21_in       = r21_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      z_in         = z_ff;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_z_in     = rsp_z_ff;
      rsp_head_in  = rsp_head_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      cord_start   = 1'b0;
      cord_angle   = pitch_ff;
      mul_en       = 1'b0;
      mul_a        = dist_ff;
      mul_b        = sp_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_beat && req_bus.imu_valid) begin
               dist_prev_in = req_bus.travelled;
               yaw_prev_in  = req_bus.yaw_raw;
               if (!started_ff) begin
                  origin_in  = req_bus.yaw_raw;
                  started_in = 1'b1;
               end else begin
                  drift_in   = drift_new;
                  head_in    = head_new;
                  pitch_in   = req_bus.pitch_angle;
                  dist_in    = req_bus.travelled - dist_prev_ff;
                  cord_start = 1'b1;
                  cord_angle = head_new;
                  state_in   = S_HEAD;
               end
            end
         end
         S_HEAD: begin
            if (!cord_busy) begin
               ch_in      = cord_cos;
               sh_in      = cord_sin;
               cord_start = 1'b1;
               state_in   = S_PITCH;
            end
         end
         S_PITCH: begin
            if (!cord_busy) begin
               cp_in    = cord_cos;
               sp_in    = cord_sin;
               state_in = S_R11;
            end
         end
         // multiplier result lands one state after its operands
         S_R11: begin
            mul_en   = 1'b1;
            mul_a    = ch_ff;
            mul_b    = cp_ff;
            state_in = S_R21;
         end
         S_R21: begin
            mul_en   = 1'b1;
            mul_a    = sh_ff;
            mul_b    = cp_ff;
            r11_in   = prod[61:30];
            state_in = S_PX;
         end
         S_PX: begin
            mul_en   = 1'b1;
            mul_a    = dist_ff;
            mul_b    = r11_ff;
            r21_in   = prod[61:30];
            state_in = S_PY;
         end
         S_PY: begin
            mul_en   = 1'b1;
            mul_a    = dist_ff;
            mul_b    = r21_ff;
            x_in     = x_ff + inc;
            state_in = S_PZ;
         end
         S_PZ: begin
            mul_en   = 1'b1;
            mul_a    = dist_ff;
            mul_b    = sp_ff;
            y_in     = y_ff + inc;
            state_in = S_ZACC;
         end
         S_ZACC: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               z_in         = z_ff - inc;
               rsp_x_in     = x_ff;
               rsp_y_in     = y_ff;
               rsp_z_in     = z_ff - inc;
               rsp_head_in  = head_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         thr_ff       <= THRESH_RESET;
         started_ff   <= 1'b0;
         origin_ff    <= '0;
         yaw_prev_ff  <= '0;
         drift_ff     <= '0;
         dist_prev_ff <= '0;
         x_ff         <= '0;
         y_ff         <= '0;
         z_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         if (csr_we) begin
            thr_ff <= csr_wdata;
         end
         started_ff   <= started_in;
         origin_ff    <= origin_in;
         yaw_prev_ff  <= yaw_prev_in;
         drift_ff     <= drift_in;
         dist_prev_ff <= dist_prev_in;
         x_ff         <= x_in;
         y_ff         <= y_in;
         z_ff         <= z_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      head_ff     <= head_in;
      pitch_ff    <= pitch_in;
      dist_ff     <= dist_in;
      ch_ff       <= ch_in;
      sh_ff       <= sh_in;
      cp_ff       <= cp_in;
      sp_ff       <= sp_in;
      r11_ff      <= r11_in;
      r21_ff      <= r21_in;
      rsp_x_ff    <= rsp_x_in;
      rsp_y_ff    <= rsp_y_in;
      rsp_z_ff    <= rsp_z_in;
      rsp_head_ff <= rsp_head_in;
   end

   assign req_bus.ready   = (state_ff == S_IDLE);
   assign rsp_bus.valid   = rsp_valid_ff;
   assign rsp_bus.pos_x   = rsp_x_ff;
   assign rsp_bus.pos_y   = rsp_y_ff;
   assign rsp_bus.pos_z   = rsp_z_ff;
   assign rsp_bus.heading = rsp_head_ff;

   a_work_starts: assert property (@(posedge clock) disable iff (reset)
      req_beat && req_bus.imu_valid && started_ff |=> state_ff == S_HEAD)
      else $error("valid beat after start did not launch the heading pass");
   a_invalid_noop: assert property (@(posedge clock) disable iff (reset)
      req_beat && !req_bus.imu_valid |=> $stable(started_ff) && $stable(drift_ff)
                                         && $stable(dist_prev_ff))
      else $error("invalid IMU beat changed state");
   a_cordic_free: assert property (@(posedge clock) disable iff (reset)
      cord_start |-> !cord_busy)
      else $error("CORDIC restarted while busy");
   a_result_out: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_ZACC && (!rsp_valid_ff || rsp_bus.ready) |=> rsp_valid_ff
      && state_ff == S_IDLE)
      else $error("finished item did not reach the output register");

endmodule

/* rtl/odr_cordic.sv */
module odr_cordic (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  odr_pkg::angle_type  angle,
   output logic                busy,
   output odr_pkg::q30_type    cos_q,
   output odr_pkg::q30_type    sin_q
);
   import odr_pkg::*;

   q30_type              x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic [ITER_W-1:0]    cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 flip_ff, flip_in;
   logic signed [16:0]   ang_ext, ang_red;
   q30_type              x_sh, y_sh, at;

   assign ang_ext = {angle[15], angle};
   assign x_sh    = x_ff >>> cnt_ff;
   assign y_sh    = y_ff >>> cnt_ff;
   assign at      = atan_val(ATAN_IDX_W'(cnt_ff));

   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      flip_in = flip_ff;
      ang_red = ang_ext;
      if (start) begin
         // fold into +-quarter turn, negate results at the end
         flip_in = 1'b0;
         if (ang_ext > 17'sd16384) begin
            ang_red = ang_ext - 17'sd32768;
            flip_in = 1'b1;
         end else if (ang_ext < -17'sd16384) begin
            ang_red = ang_ext + 17'sd32768;
            flip_in = 1'b1;
         end
         x_in    = CORDIC_GAIN;
         y_in    = '0;
         z_in    = {ang_red[15:0], 16'd0};
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!z_ff[31]) begin
            x_in = x_ff - y_sh;
            y_in = y_ff + x_sh;
            z_in = z_ff - at;
         end else begin
            x_in = x_ff + y_sh;
            y_in = y_ff - x_sh;
            z_in = z_ff + at;
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == ITER_W'(CORDIC_ITERS - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      flip_ff <= flip_in;
   end

   assign busy  = busy_ff;
   assign cos_q = flip_ff ? -x_ff : x_ff;
   assign sin_q = flip_ff ? -y_ff : y_ff;

   a_count_idle: assert property (@(posedge clock) disable iff (reset)
      !busy_ff && !start |=> $stable(cnt_ff))
      else $error("iteration counter moved while idle");
   a_start_clears: assert property (@(posedge clock) disable iff (reset)
      start |=> busy_ff && cnt_ff == '0)
      else $error("start did not arm the rotation loop");
   a_finish: assert property (@(posedge clock) disable iff (reset)
      busy_ff && !start && cnt_ff == ITER_W'(CORDIC_ITERS - 1) |=> !busy_ff)
      else $error("rotation loop overran");

endmodule

/* rtl/odr_mul.sv */
module odr_mul (
   input  logic                 clock,
   input  logic                 enable,
   input  odr_pkg::q30_type     op_a,
   input  odr_pkg::q30_type     op_b,
   output logic signed [63:0]   prod
);
   import odr_pkg::*;

   logic signed [63:0] prod_ff, prod_in;

   assign prod_in = op_a * op_b;

   always_ff @(posedge clock) begin
      if (enable) begin
         prod_ff <= prod_in;
      end
   end

   assign prod = prod_ff;

endmodule

/* test/testbench.sv */
import odr_pkg::*;

typedef struct packed {
   logic      imu_valid;
   angle_type yaw;
   angle_type pitch;
   dist_type  travelled;
   dist_type  speed;
} odo_sample_t;

typedef struct packed {
   pos_type   x;
   pos_type   y;
   pos_type   z;
   angle_type heading;
} pose_t;

class pose_tracker;
   thresh_type still_thresh = THRESH_RESET;
   bit         started;
   angle_type  yaw_origin;
   angle_type  yaw_last;
   angle_type  drift_acc;
   dist_type   dist_last;
   pos_type    x_acc;
   pos_type    y_acc;
   pos_type    z_acc;
   pose_t      expected_poses[$];
   int         mismatches;
   longint     atan_lut[24] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772,
      166886, 83443, 41722, 20861, 10430, 5215,
      2608, 1304, 652, 326, 163, 81};

   // cos/sin in Q2.30; angles past +-90 deg are folded by half a turn
   function void sincos(input angle_type ang, output longint c, output longint s);
      longint a;
      longint x;
      longint y;
      longint z;
      longint nx;
      bit     flip;
      int     n;
      a = ang;
      flip = 1'b0;
      if (a > 16384) begin
         a -= 32768;
         flip = 1'b1;
      end else if (a < -16384) begin
         a += 32768;
         flip = 1'b1;
      end
      z = a * 65536;
      x = CORDIC_GAIN;
      y = 0;
      n = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
      for (int i = 0; i < n; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i);
            y  = y + (x >>> i);
            z  = z - atan_lut[i];
         end else begin
            nx = x + (y >>> i);
            y  = y - (x >>> i);
            z  = z + atan_lut[i];
         end
         x = nx;
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
   endfunction

   function void track_sample(odo_sample_t smp);
      longint    spd;
      longint    mag;
      longint    step_len;
      longint    ch;
      longint    sh;
      longint    cp;
      longint    sp;
      longint    r11;
      longint    r21;
      angle_type head;
      dist_type  delta;
      if (!smp.imu_valid)
         return;
      if (!started) begin
         yaw_origin = smp.yaw;
         yaw_last   = smp.yaw;
         dist_last  = smp.travelled;
         started    = 1'b1;
         return;
      end
      spd = smp.speed;
      mag = (spd < 0) ? -spd : spd;
      if (mag < longint'(still_thresh))
         drift_acc = drift_acc + smp.yaw - yaw_last;
      yaw_last = smp.yaw;
      head = smp.yaw - yaw_origin - drift_acc;
      delta = smp.travelled - dist_last;
      dist_last = smp.travelled;
      step_len = delta;
      sincos(head, ch, sh);
      sincos(smp.pitch, cp, sp);
      r11 = (ch * cp) >>> 30;
      r21 = (sh * cp) >>> 30;
      x_acc = x_acc + ((step_len * r11) >>> 30);
      y_acc = y_acc + ((step_len * r21) >>> 30);
      z_acc = z_acc - ((step_len * sp) >>> 30);
      expected_poses.push_back('{x_acc, y_acc, z_acc, head});
   endfunction

   function void check_pose(pose_t got);
      pose_t want;
      if (expected_poses.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("unexpected pose beat: x=%0d y=%0d z=%0d heading=%0d",
                     got.x, got.y, got.z, got.heading);
         return;
      end
      want = expected_poses.pop_front();
      if (got.x !== want.x || got.y !== want.y || got.z !== want.z ||
          got.heading !== want.heading) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("pose mismatch: expected x=%0d y=%0d z=%0d heading=%0d",
                     want.x, want.y, want.z, want.heading);
            $display("               actual   x=%0d y=%0d z=%0d heading=%0d",
                     got.x, got.y, got.z, got.heading);
         end
      end
   endfunction
endclass

module testbench;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int DRAIN_CYCLES = 60;

   logic       clock;
   logic       reset;
   logic       csr_we;
   thresh_type csr_wdata;
   bit         steady;
   int         cycles;
   dist_type   trav_now;
   angle_type  yaw_now;

   pose_tracker sb = new;

   odr_req_if req_bus ();
   odr_rsp_if rsp_bus ();

   odometry_imu_dead_reckoning uut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // result side: sample pre-edge values, then pick next ready
   initial begin
      pose_t seen;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            seen.x       = rsp_bus.pos_x;
            seen.y       = rsp_bus.pos_y;
            seen.z       = rsp_bus.pos_z;
            seen.heading = rsp_bus.heading;
            sb.check_pose(seen);
         end
         rsp_bus.ready <= steady || ($urandom_range(99) >= 22);
      end
   end

   // valid stays high between back-to-back beats; gaps only drop it
   task automatic send_beat(input odo_sample_t smp);
      while (!steady && $urandom_range(99) < 22) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.imu_valid   <= smp.imu_valid;
      req_bus.yaw_raw     <= smp.yaw;
      req_bus.pitch_angle <= smp.pitch;
      req_bus.travelled   <= smp.travelled;
      req_bus.speed       <= smp.speed;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
      sb.track_sample(smp);
   endtask

   task automatic send_fields(input logic v, input angle_type yaw, input angle_type pitch,
                              input dist_type trav, input dist_type spd);
      odo_sample_t smp;
      smp = '{v, yaw, pitch, trav, spd};
      if (v) begin
         trav_now = trav;
         yaw_now  = yaw;
      end
      send_beat(smp);
   endtask

   // picks the yaw that lands the corrected heading exactly on h
   task automatic send_heading(input angle_type h);
      angle_type yaw;
      yaw = sb.yaw_origin + sb.drift_acc + h;
      send_fields(1'b1, yaw, 16'sd2000, trav_now + 32'sd40000, 32'sd1000000);
   endtask

   task automatic write_threshold(input thresh_type v);
      while (sb.expected_poses.size() != 0)
         @(posedge clock);
      // a trailing ignored beat may still be in flight
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      sb.still_thresh = v;
   endtask

   task automatic run_directed();
      send_fields(1'b0, 12345, -1, -1, 0);
      send_fields(1'b1, 1000, 0, 5000, 0);
      send_fields(1'b0, 16'sh8000, 32767, 32'sh7fffffff, 32'sh80000000);
      send_fields(1'b1, 1300, 0, 70536, 0);
      send_fields(1'b1, 1300, 0, 70536, 654);
      send_fields(1'b1, 2000, 100, 200000, 655);
      send_fields(1'b1, 1900, -100, 300000, -654);
      send_fields(1'b1, 1700, 16384, 400000, -655);
      send_fields(1'b1, 32767, -16384, 500000, 32'sh80000000);
      send_fields(1'b1, 16'sh8000, 16385, 600000, 32'sh7fffffff);
      send_fields(1'b1, 0, -16385, 700000, 1000000);
      send_fields(1'b1, 5, 32767, 32'sh7fffffff, 1000000);
      send_fields(1'b1, 5, 16'sh8000, 32'sh80000000, 1000000);
      send_fields(1'b1, 5, 8000, 0, 1000000);
      send_heading(16384);
      send_heading(16385);
      send_heading(-16384);
      send_heading(-16385);
      send_heading(16'sh8000);
      send_heading(32767);
      send_heading(0);
   endtask

   task automatic run_random(input int n_valid);
      odo_sample_t smp;
      int          pick;
      int          done;
      int          mag;
      done = 0;
      while (done < n_valid) begin
         pick = $urandom_range(99);
         smp.imu_valid = 1'b1;
         if (pick < 8) begin
            smp.imu_valid = 1'b0;
            smp.yaw       = angle_type'($urandom);
            smp.pitch     = angle_type'($urandom);
            smp.travelled = $urandom;
            smp.speed     = $urandom;
         end else if (pick < 18) begin
            smp.yaw       = angle_type'($urandom);
            smp.pitch     = angle_type'($urandom);
            smp.travelled = $urandom;
            smp.speed     = $urandom;
            yaw_now  = smp.yaw;
            trav_now = smp.travelled;
         end else begin
            // plausible drive: mostly small yaw steps, mostly forward odometry, speeds often near the threshold
            if ($urandom_range(9) == 0)
               yaw_now = angle_type'($urandom);
            else
               yaw_now = angle_type'(int'(yaw_now) + int'($urandom_range(1200)) - 600);
            if ($urandom_range(19) == 0)
               trav_now = trav_now - int'($urandom_range(20000));
            else
               trav_now = trav_now + int'($urandom_range(60000));
            pick = $urandom_range(9);
            if (pick < 5)
               mag = $urandom_range(2 * int'(sb.still_thresh) + 2);
            else if (pick < 9)
               mag = $urandom_range(400000);
            else
               mag = $urandom;
            smp.yaw       = yaw_now;
            smp.pitch     = ($urandom_range(4) == 0) ? angle_type'($urandom)
                                                     : angle_type'(int'($urandom_range(6000)) - 3000);
            smp.travelled = trav_now;
            smp.speed     = $urandom_range(1) ? -mag : mag;
         end
         send_beat(smp);
         if (smp.imu_valid)
            done++;
      end
      req_bus.valid <= 1'b0;
   endtask

   initial begin
      reset               <= 1'b1;
      csr_we              <= 1'b0;
      csr_wdata           <= '0;
      cycles              <= 0;
      req_bus.valid       <= 1'b0;
      req_bus.imu_valid   <= 1'b0;
      req_bus.yaw_raw     <= '0;
      req_bus.pitch_angle <= '0;
      req_bus.travelled   <= '0;
      req_bus.speed       <= '0;
      steady   = 1'b0;
      trav_now = '0;
      yaw_now  = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      run_directed();
      req_bus.valid <= 1'b0;

      write_threshold(16'd0);
      run_random(250);
      write_threshold(16'hFFFF);
      run_random(250);
      steady = 1'b1;
      write_threshold(THRESH_RESET);
      run_random(250);
      steady = 1'b0;
      write_threshold(thresh_type'($urandom_range(1, 65534)));
      run_random(250);

      while (sb.expected_poses.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.mismatches == 0 && sb.expected_poses.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
